// File: src/pli_pkg.sv
// Shared types and constants for the positional list insert/delete core.
// Used by the controller, the datapath and the top level; depends on nothing.
package pli_pkg;

   localparam int CAPACITY_DEF = 128;

   localparam int POS_W   = 8;
   localparam int VALUE_W = 32;
   localparam int LEN_W   = 8;
   localparam int STAT_W  = 2;

   typedef enum logic {
      FUNC_INSERT = 1'b0,
      FUNC_DELETE = 1'b1
   } func_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_RANGE = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_INS_LOOP,
      ST_INS_WR,
      ST_DEL_CAP,
      ST_DEL_LOOP,
      ST_DEL_WR,
      ST_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic latch;        // capture the accepted item
      logic check;        // range/full check, set status, init index, read position
      logic rd_prev;      // read entry below the index
      logic rd_next;      // read entry above the index
      logic wr_shift;     // write read data at the index
      logic wr_val;       // write the inserted value at the index
      logic idx_dec;
      logic idx_inc;
      logic cap_removed;  // capture the deleted entry
      logic cnt_inc;
      logic cnt_dec;
      logic out_load;     // load the result register
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_delete;
      logic error;
      logic ins_at_pos;   // index reached the insert slot
      logic del_at_end;   // index reached the last entry
      logic out_busy;     // result register still held by the sink
   } dp_stat_type;

endpackage

// File: src/pli_ctrl.sv
// Controller state machine for the positional list core.
// Sequences checks, entry moves and the result load; uses pli_pkg.
module pli_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  pli_pkg::dp_stat_type stat,
   output pli_pkg::dp_cmd_type  cmd
);

   pli_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pli_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         pli_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               state_in  = pli_pkg::ST_CHECK;
            end
         end
         pli_pkg::ST_CHECK: begin
            cmd.check = 1'b1;
            if (stat.error) begin
               state_in = pli_pkg::ST_DONE;
            end else if (stat.is_delete) begin
               state_in = pli_pkg::ST_DEL_CAP;
            end else begin
               state_in = pli_pkg::ST_INS_LOOP;
            end
         end
         pli_pkg::ST_INS_LOOP: begin
            if (stat.ins_at_pos) begin
               cmd.wr_val  = 1'b1;
               cmd.cnt_inc = 1'b1;
               state_in    = pli_pkg::ST_DONE;
            end else begin
               cmd.rd_prev = 1'b1;
               state_in    = pli_pkg::ST_INS_WR;
            end
         end
         pli_pkg::ST_INS_WR: begin
            cmd.wr_shift = 1'b1;
            cmd.idx_dec  = 1'b1;
            state_in     = pli_pkg::ST_INS_LOOP;
         end
         pli_pkg::ST_DEL_CAP: begin
            cmd.cap_removed = 1'b1;
            state_in        = pli_pkg::ST_DEL_LOOP;
         end
         pli_pkg::ST_DEL_LOOP: begin
            if (stat.del_at_end) begin
               cmd.cnt_dec = 1'b1;
               state_in    = pli_pkg::ST_DONE;
            end else begin
               cmd.rd_next = 1'b1;
               state_in    = pli_pkg::ST_DEL_WR;
            end
         end
         pli_pkg::ST_DEL_WR: begin
            cmd.wr_shift = 1'b1;
            cmd.idx_inc  = 1'b1;
            state_in     = pli_pkg::ST_DEL_LOOP;
         end
         pli_pkg::ST_DONE: begin
            // hold until the previous result has been taken
            if (!stat.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = pli_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pli_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// File: src/pli_dp.sv
// Datapath for the positional list core: entry memory, count, index, result register.
// Driven by pli_ctrl through command and status structs; uses pli_pkg.
module pli_dp #(
   parameter int CAPACITY = pli_pkg::CAPACITY_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pli_pkg::dp_cmd_type           cmd,
   output pli_pkg::dp_stat_type          stat,
   input  logic                          in_func,
   input  logic [pli_pkg::POS_W-1:0]     in_position,
   input  logic signed [pli_pkg::VALUE_W-1:0] in_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [pli_pkg::STAT_W-1:0]    rsp_status,
   output logic signed [pli_pkg::VALUE_W-1:0] rsp_removed,
   output logic [pli_pkg::LEN_W-1:0]     rsp_length
);

   localparam int AW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = ((CW > pli_pkg::POS_W) ? CW : pli_pkg::POS_W) + 1;

   logic [pli_pkg::VALUE_W-1:0] mem [CAPACITY];

   logic                          func_ff;
   logic [pli_pkg::POS_W-1:0]     pos_ff;
   logic [pli_pkg::VALUE_W-1:0]   val_ff;
   logic [CW-1:0]                 count_ff, count_in;
   logic [AW-1:0]                 idx_ff, idx_in;
   logic [pli_pkg::VALUE_W-1:0]   rd_ff;
   pli_pkg::status_type           code_ff;
   logic [pli_pkg::VALUE_W-1:0]   removed_ff;
   logic                          rsp_valid_ff;
   logic [pli_pkg::STAT_W-1:0]    rsp_status_ff;
   logic [pli_pkg::VALUE_W-1:0]   rsp_removed_ff;
   logic [pli_pkg::LEN_W-1:0]     rsp_length_ff;

   logic [CMPW-1:0]      pos_ext, cnt_ext;
   logic [AW-1:0]        pm1, last_idx, rd_addr;
   logic                 bad_pos, full, rd_en, wr_en;
   logic [pli_pkg::VALUE_W-1:0] wr_data;
   pli_pkg::status_type  code_now;

   assign pos_ext  = CMPW'(pos_ff);
   assign cnt_ext  = CMPW'(count_ff);
   assign pm1      = AW'(pos_ext - CMPW'(1));
   assign last_idx = AW'(cnt_ext - CMPW'(1));
   assign full     = (cnt_ext == CMPW'(CAPACITY));

   always_comb begin
      if (func_ff == pli_pkg::FUNC_DELETE) begin
         bad_pos = (pos_ext == '0) || (pos_ext > cnt_ext);
      end else begin
         bad_pos = (pos_ext == '0) || (pos_ext > cnt_ext + CMPW'(1));
      end
      if (bad_pos) begin
         code_now = pli_pkg::STAT_RANGE;
      end else if (func_ff == pli_pkg::FUNC_INSERT && full) begin
         code_now = pli_pkg::STAT_FULL;
      end else begin
         code_now = pli_pkg::STAT_OK;
      end
   end

   assign stat.is_delete  = (func_ff == pli_pkg::FUNC_DELETE);
   assign stat.error      = (code_now != pli_pkg::STAT_OK);
   assign stat.ins_at_pos = (idx_ff == pm1);
   assign stat.del_at_end = (idx_ff == last_idx);
   assign stat.out_busy   = rsp_valid_ff && !rsp_ready;

   // read below the index on insert, above it on delete, the target slot on check
   always_comb begin
      if (cmd.rd_prev) begin
         rd_addr = idx_ff - AW'(1);
      end else if (cmd.rd_next) begin
         rd_addr = idx_ff + AW'(1);
      end else begin
         rd_addr = pm1;
      end
   end
   assign rd_en   = cmd.rd_prev || cmd.rd_next || cmd.check;
   assign wr_en   = cmd.wr_shift || cmd.wr_val;
   assign wr_data = cmd.wr_val ? val_ff : rd_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[idx_ff] <= wr_data;
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.check) begin
         idx_in = (func_ff == pli_pkg::FUNC_DELETE) ? pm1 : AW'(count_ff);
      end else if (cmd.idx_dec) begin
         idx_in = idx_ff - AW'(1);
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + AW'(1);
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.latch) begin
         func_ff <= in_func;
         pos_ff  <= in_position;
         val_ff  <= in_value;
      end
      if (cmd.check) begin
         code_ff    <= code_now;
         removed_ff <= '0;
      end else if (cmd.cap_removed) begin
         removed_ff <= rd_ff;
      end
      if (cmd.out_load) begin
         rsp_status_ff  <= code_ff;
         rsp_removed_ff <= removed_ff;
         rsp_length_ff  <= pli_pkg::LEN_W'(count_ff);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_removed = rsp_removed_ff;
   assign rsp_length  = rsp_length_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_cnt_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.cnt_inc && cmd.cnt_dec))
      else $error("count raised and lowered at once");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid_ff && !rsp_ready))
      else $error("result register reloaded while still held");

   a_ins_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_inc |-> !full)
      else $error("insert into a full list");

endmodule

// File: src/positional_list_insert_delete_core.sv
// Positional list insert/delete core: top level joining pli_ctrl and pli_dp.
// Errors go from the check to the result load; an insert shifts entries up from
// the tail to its slot, a delete captures its entry and shifts the rest down, one
// entry at a time through the single-port entry memory; a new item is taken once
// the previous one has reached the result register.
// Reset clears the entry count and the control state; entry storage is not cleared.
module positional_list_insert_delete_core #(
   parameter int CAPACITY = pli_pkg::CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // position[7:0], value[39:8]
   input  logic        req_tuser,   // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // removed_value[31:0], list_length[39:32]
   output logic [1:0]  rsp_tuser    // status
);

   pli_pkg::dp_cmd_type  cmd;
   pli_pkg::dp_stat_type stat;

   logic signed [pli_pkg::VALUE_W-1:0] removed_value;
   logic [pli_pkg::LEN_W-1:0]          list_length;

   pli_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   pli_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .in_func     (req_tuser),
      .in_position (req_tdata[7:0]),
      .in_value    (req_tdata[39:8]),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_status  (rsp_tuser),
      .rsp_removed (removed_value),
      .rsp_length  (list_length)
   );

   assign rsp_tdata = {list_length, removed_value};

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for positional_list_insert_delete_core: directed, fill/full,
// back-pressure and random insert/delete items checked against a queue model.
// Depends on pli_pkg and the core; stands alone otherwise.
module tb_top;

   localparam int LIST_CAP   = pli_pkg::CAPACITY_DEF;
   localparam int MAX_CYCLES = 3_000_000;
   // longest single operation plus a receiver stall
   localparam int DRAIN_TAIL = 2 * LIST_CAP + 40;

   typedef struct {
      pli_pkg::status_type status;
      logic [31:0]         removed;
      logic [7:0]          length;
   } list_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // position[7:0], value[39:8]
   logic        req_tuser = 1'b0; // func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // removed_value[31:0], list_length[39:32]
   logic [1:0]  rsp_tuser;        // status

   logic [31:0]     list_model[$];
   list_result_type pending_results[$];
   int              failures = 0;
   int              cycles = 0;
   bit              idle_on = 1'b1;
   int              sink_hold_len = 0;

   positional_list_insert_delete_core #(.CAPACITY(LIST_CAP)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > MAX_CYCLES) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycles, pending_results.size());
         $display("status: fail");
         $finish;
      end
   end

   // Update the list model with one accepted item and return what the core must report.
   function automatic list_result_type apply_list_op(pli_pkg::func_type f, logic [7:0] pos,
                                                     logic [31:0] val);
      list_result_type r;
      int              len;
      len       = list_model.size();
      r.status  = pli_pkg::STAT_OK;
      r.removed = '0;
      if (f == pli_pkg::FUNC_INSERT) begin
         if (pos < 1 || pos > len + 1)
            r.status = pli_pkg::STAT_RANGE;
         else if (len >= LIST_CAP)
            r.status = pli_pkg::STAT_FULL;
         else
            list_model.insert(pos - 1, val);
      end else begin
         if (pos < 1 || pos > len) begin
            r.status = pli_pkg::STAT_RANGE;
         end else begin
            r.removed = list_model[pos - 1];
            list_model.delete(pos - 1);
         end
      end
      r.length = 8'(list_model.size());
      return r;
   endfunction

   task automatic note_failure(input string what);
      failures++;
      if (failures <= 10)
         $display("[%0t] %s", $time, what);
   endtask

   // Offer one item and hold it until accepted; valid stays high for a following item.
   task automatic send_item(input pli_pkg::func_type f, input logic [7:0] pos,
                            input logic [31:0] val);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= f;
      req_tdata  <= {val, pos};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(apply_list_op(f, pos, val));
   endtask

   // Drop valid and wait for every outstanding result.
   task automatic wait_results_done();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic random_item(input int band);
      int len;
      len = list_model.size();
      if ($urandom_range(0, 99) < 12)
         send_item(pli_pkg::func_type'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                   $urandom());
      else if (len == 0 || (len < band && $urandom_range(0, 99) < 60) ||
               (len >= band && $urandom_range(0, 99) < 25))
         send_item(pli_pkg::FUNC_INSERT, 8'($urandom_range(1, len + 1)), $urandom());
      else
         send_item(pli_pkg::FUNC_DELETE, 8'($urandom_range(1, len)), $urandom());
   endtask

   // Result sink: random stall bursts, plus a long hold-off on request.
   initial begin : sink
      int n;
      forever begin
         @(posedge clock);
         if (sink_hold_len > 0) begin
            n = sink_hold_len;
            sink_hold_len = 0;
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : result_check
      list_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            note_failure($sformatf("unexpected result stat=%0d removed=%h len=%0d",
                                   rsp_tuser, rsp_tdata[31:0], rsp_tdata[39:32]));
         end else begin
            want = pending_results.pop_front();
            if (rsp_tuser !== want.status || rsp_tdata[31:0] !== want.removed ||
                rsp_tdata[39:32] !== want.length)
               note_failure($sformatf(
                  "mismatch: exp stat=%0d removed=%h len=%0d, got stat=%0d removed=%h len=%0d",
                  want.status, want.removed, want.length,
                  rsp_tuser, rsp_tdata[31:0], rsp_tdata[39:32]));
         end
      end
   end

   task automatic test_directed();
      // empty list: every delete and any insert other than at position 1 is out of range
      send_item(pli_pkg::FUNC_DELETE, 8'd1, 32'h0000_0000);
      send_item(pli_pkg::FUNC_DELETE, 8'd0, 32'hFFFF_FFFF);
      send_item(pli_pkg::FUNC_INSERT, 8'd0, 32'h1234_5678);
      send_item(pli_pkg::FUNC_INSERT, 8'd2, 32'h0000_0000);
      send_item(pli_pkg::FUNC_INSERT, 8'd255, 32'hFFFF_FFFF);
      // build min, 0, max, -1 through head, tail and middle inserts
      send_item(pli_pkg::FUNC_INSERT, 8'd1, 32'h7FFF_FFFF);
      send_item(pli_pkg::FUNC_INSERT, 8'd1, 32'h8000_0000);
      send_item(pli_pkg::FUNC_INSERT, 8'd3, 32'hFFFF_FFFF);
      send_item(pli_pkg::FUNC_INSERT, 8'd2, 32'h0000_0000);
      send_item(pli_pkg::FUNC_INSERT, 8'd6, 32'h5555_5555);
      send_item(pli_pkg::FUNC_INSERT, 8'd5, 32'hAAAA_AAAA);
      send_item(pli_pkg::FUNC_DELETE, 8'd6, 32'h0000_0000);
      send_item(pli_pkg::FUNC_DELETE, 8'd255, 32'h0000_0000);
      send_item(pli_pkg::FUNC_DELETE, 8'd0, 32'h0000_0000);
      // value field is ignored on delete
      send_item(pli_pkg::FUNC_DELETE, 8'd5, 32'hFFFF_FFFF);
      send_item(pli_pkg::FUNC_DELETE, 8'd1, 32'h0000_0000);
      send_item(pli_pkg::FUNC_DELETE, 8'd2, 32'h0000_0000);
      send_item(pli_pkg::FUNC_DELETE, 8'd2, 32'h0000_0000);
      send_item(pli_pkg::FUNC_DELETE, 8'd1, 32'h0000_0000);
      send_item(pli_pkg::FUNC_DELETE, 8'd1, 32'h0000_0000);
      wait_results_done();
   endtask

   task automatic test_fill_full();
      while (list_model.size() < LIST_CAP)
         send_item(pli_pkg::FUNC_INSERT, 8'($urandom_range(1, list_model.size() + 1)),
                   $urandom());
      send_item(pli_pkg::FUNC_INSERT, 8'($urandom_range(1, LIST_CAP + 1)), $urandom());
      // range check wins over the full check
      send_item(pli_pkg::FUNC_INSERT, 8'd0, $urandom());
      send_item(pli_pkg::FUNC_INSERT, 8'(LIST_CAP + 2), $urandom());
      send_item(pli_pkg::FUNC_INSERT, 8'(LIST_CAP + 1), $urandom());
      send_item(pli_pkg::FUNC_DELETE, 8'(LIST_CAP + 1), $urandom());
      send_item(pli_pkg::FUNC_DELETE, 8'(LIST_CAP), $urandom());
      while (list_model.size() > 8)
         send_item(pli_pkg::FUNC_DELETE, 8'($urandom_range(1, list_model.size())),
                   $urandom());
      wait_results_done();
   endtask

   task automatic test_backpressure();
      // sink holds off while the sender keeps offering items
      sink_hold_len = 400;
      repeat (24) random_item(16);
      wait_results_done();
   endtask

   task automatic test_random();
      int band;
      band = 16;
      for (int i = 0; i < 1300; i++) begin
         if (i % 100 == 0)
            band = $urandom_range(2, 40);
         random_item(band);
         if ($urandom_range(0, 199) == 0)
            wait_results_done();
      end
      wait_results_done();
   endtask

   task automatic test_no_idle();
      idle_on = 1'b0;
      for (int i = 0; i < 220; i++)
         random_item(12);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_fill_full();
      test_backpressure();
      test_random();
      test_no_idle();
      wait_results_done();
      repeat (DRAIN_TAIL) @(posedge clock);
      if (failures == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// File: filelist.f
src/pli_pkg.sv
src/pli_ctrl.sv
src/pli_dp.sv
src/positional_list_insert_delete_core.sv
sim/tb_top.sv
